### rtl/bds2x2_pkg.sv
package bds2x2_pkg;

  // Payload and register widths
  localparam int unsigned PixW      = 8;
  localparam int unsigned PairW     = 9;
  localparam int unsigned ImgWidthW = 13;
  localparam int unsigned ImgHeightW = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  // Reset values of the frame size registers
  localparam int unsigned ImgWidthRst  = 640;
  localparam int unsigned ImgHeightRst = 480;

  // Default line buffer sizing
  localparam int unsigned MaxWidthDefault = 4096;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Line buffer operation issued with one pixel beat
  typedef struct packed {
    logic wr;    // store the pair sum of an even row
    logic rd;    // fetch the pair sum above, result follows
    logic last;  // bottom-right pixel of the final block of the frame
  } line_op_t;

endpackage

### rtl/bds2x2_if.sv
interface bds2x2_pix_if;
  import bds2x2_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bds2x2_res_if;
  import bds2x2_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] out_pixel;
  logic            frame_last;

  modport source (output valid, output out_pixel, output frame_last, input ready);
  modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

interface bds2x2_cfg_if;
  import bds2x2_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bds2x2_line_acc.sv
module bds2x2_line_acc #(
  parameter int unsigned LINE_DEPTH = 2048,
  parameter int unsigned AW         = 11
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  bds2x2_pkg::line_op_t             op_i,
  input  logic [AW-1:0]                    slot_i,
  input  logic [bds2x2_pkg::PairW-1:0]     pair_i,
  input  logic                             adv_i,
  output logic                             vld_o,
  output logic [bds2x2_pkg::PixW-1:0]      avg_o,
  output logic                             last_o
);
  import bds2x2_pkg::*;

  logic [PairW-1:0] mem [LINE_DEPTH];
  logic [PairW-1:0] above_q;
  logic [PairW-1:0] pair_q;
  logic             last_q;
  logic             vld_q;
  logic [PairW:0]   sum;

  // Single port: an even row writes, an odd row reads, never both in one beat
  always_ff @(posedge clk_i) begin
    if (en_i && op_i.wr) begin
      mem[slot_i] <= pair_i;
    end
    if (en_i && op_i.rd) begin
      above_q <= mem[slot_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && op_i.rd) begin
      pair_q <= pair_i;
      last_q <= op_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i && op_i.rd) begin
      vld_q <= 1'b1;
    end else if (adv_i) begin
      vld_q <= 1'b0;
    end
  end

  // Round to nearest: (above + pair + 2) >> 2
  assign sum    = {1'b0, above_q} + {1'b0, pair_q} + (PairW+1)'(2);
  assign avg_o  = sum[PairW:2];
  assign last_o = last_q;
  assign vld_o  = vld_q;

endmodule

### rtl/box_downsample_2x2_u8_top.sv
// 2x2 box downsampler for 8-bit raster pixels. Pixels enter on pix_i in
// raster order, one beat per pixel, and each 2x2 block of the frame leaves
// res_o as one beat carrying the rounded average (sum + 2) >> 2; frame_last
// marks the final block of the frame. An odd last column or odd last row is
// swallowed without output. The block takes one pixel per clock sustained:
// the single-port line buffer ((MAX_WIDTH+1)/2 entries of 9 bits) sees one write
// on even rows or one read on odd rows per pixel, so the port never limits
// the rate. A result goes through the average stage and the output register
// on its way to res_o after its bottom-right pixel is accepted, and pix_i
// stalls only when both the average stage and the output register are full
// and res_o is held. Frame size is set through cfg_i (index 0: width, 0 read
// as 1, clamped to MAX_WIDTH; index 1: height, 0 read as 1); write it only
// while no result is pending. The line buffer is not cleared after reset:
// every entry is written by an even row before the odd row below reads it.
module box_downsample_2x2_u8_top #(
  parameter int unsigned MAX_WIDTH = bds2x2_pkg::MaxWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bds2x2_pix_if.sink          pix_i,
  bds2x2_res_if.source        res_o,
  bds2x2_cfg_if.sink          cfg_i
);
  import bds2x2_pkg::*;

  localparam int unsigned WW         = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CNT_W      = $clog2(MAX_WIDTH);
  localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CW         = (WW > ImgWidthW) ? WW : ImgWidthW;
  localparam int unsigned WidthRst   = (ImgWidthRst > MAX_WIDTH) ? MAX_WIDTH : ImgWidthRst;

  // Effective frame size, cleaned up at write time
  logic [WW-1:0]         eff_w_q, eff_w_d;
  logic [ImgHeightW-1:0] eff_h_q, eff_h_d;
  logic [CW-1:0]         w_raw;
  logic                  cfg_acc;

  // Raster position and the left pixel of the current pair
  logic [CNT_W-1:0]      col_q, col_d;
  logic [ImgHeightW-1:0] row_q, row_d;
  logic [PixW-1:0]       held_q;

  logic [WW-1:0]         col_p1;
  logic [ImgHeightW:0]   row_p1;
  logic                  col_wrap, row_wrap;
  logic                  last_c, last_r;
  logic                  pix_acc;

  line_op_t              op;
  logic [AW-1:0]         slot;
  logic [PairW-1:0]      pair;

  logic                  acc_vld;
  logic [PixW-1:0]       acc_avg;
  logic                  acc_last;
  logic                  acc_adv;

  logic                  out_vld_q;
  logic [PixW-1:0]       out_pix_q;
  logic                  out_last_q;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, a write beyond the list is dropped
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign w_raw       = CW'(cfg_i.data[ImgWidthW-1:0]);

  always_comb begin
    eff_w_d = eff_w_q;
    eff_h_d = eff_h_q;
    if (cfg_acc) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH: begin
          if (w_raw == '0) begin
            eff_w_d = WW'(1);
          end else if (w_raw > CW'(MAX_WIDTH)) begin
            eff_w_d = WW'(MAX_WIDTH);
          end else begin
            eff_w_d = WW'(w_raw);
          end
        end
        REG_IMAGE_HEIGHT: begin
          eff_h_d = (cfg_i.data[ImgHeightW-1:0] == '0) ? ImgHeightW'(1)
                                                     : cfg_i.data[ImgHeightW-1:0];
        end
        default: begin
          eff_w_d = eff_w_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= WW'(WidthRst);
      eff_h_q <= ImgHeightW'(ImgHeightRst);
    end else begin
      eff_w_q <= eff_w_d;
      eff_h_q <= eff_h_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position. Compare against the size as it stands, so a position left
  // beyond a shrunken frame wraps after the current pixel.
  // ---------------------------------------------------------------------------
  assign col_p1   = WW'(col_q) + WW'(1);
  assign row_p1   = {1'b0, row_q} + (ImgHeightW+1)'(1);
  assign col_wrap = (col_p1 >= eff_w_q);
  assign row_wrap = (row_p1 >= {1'b0, eff_h_q});
  // Last even-aligned column and row; never hit for a width or height of one
  assign last_c   = (col_p1 == {eff_w_q[WW-1:1], 1'b0});
  assign last_r   = (row_p1 == {1'b0, eff_h_q[ImgHeightW-1:1], 1'b0});

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_acc) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_p1[ImgHeightW-1:0];
      end else begin
        col_d = col_p1[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (pix_acc && !col_q[0]) begin
        held_q <= pix_i.pixel;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer access: odd columns close a pair; even rows store it, odd rows
  // fetch the pair above and send the block to the averaging stage.
  // ---------------------------------------------------------------------------
  assign pix_acc = pix_i.valid && pix_i.ready;
  assign pair    = {1'b0, held_q} + {1'b0, pix_i.pixel};
  assign slot    = AW'(col_q >> 1);
  assign op.wr   = col_q[0] && !row_q[0];
  assign op.rd   = col_q[0] && row_q[0];
  assign op.last = last_c && last_r;

  bds2x2_line_acc #(
    .LINE_DEPTH (LINE_DEPTH),
    .AW         (AW)
  ) u_line_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pix_acc),
    .op_i   (op),
    .slot_i (slot),
    .pair_i (pair),
    .adv_i  (acc_adv),
    .vld_o  (acc_vld),
    .avg_o  (acc_avg),
    .last_o (acc_last)
  );

  // ---------------------------------------------------------------------------
  // Output register: advance the average when the register is free or drains
  // this cycle; hold the pixel stream only when both stages are full.
  // ---------------------------------------------------------------------------
  assign acc_adv     = acc_vld && (!out_vld_q || res_o.ready);
  assign pix_i.ready = !acc_vld || !out_vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (acc_adv) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_adv) begin
      out_pix_q  <= acc_avg;
      out_last_q <= acc_last;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.out_pixel  = out_pix_q;
  assign res_o.frame_last = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (acc_vld && out_vld_q && !res_o.ready))
    else $error("pixel stream held while a stage is free");

  a_block_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && col_q[0] && row_q[0]) |=> acc_vld)
    else $error("bottom-right pixel did not start an average");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && !(col_q[0] && row_q[0])) |=> !acc_vld)
    else $error("average started by a pixel that closes no block");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && col_wrap && row_wrap) |=> (col_q == '0 && row_q == '0))
    else $error("position did not return to the frame origin");

endmodule
